### design/swi_pkg.sv
// ----------------------------------------------------------------------------
// swi_pkg
// Shared constants and types for the sort-with-index block.
// ----------------------------------------------------------------------------
package swi_pkg;

  localparam int KeyW      = 32;
  localparam int MaxLen    = 64;
  localparam int IdxW      = 6;
  localparam int CountW    = $clog2(MaxLen + 1);
  localparam int FifoDepth = 2;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int PaddrW    = 3;

  // register indexes
  localparam logic RegDescending = 1'b0;
  localparam logic RegSignedKeys = 1'b1;

  // one classified key on its way from front to back
  typedef struct packed {
    logic [KeyW-1:0] ord;    // key remapped so unsigned compare gives the order
    logic [IdxW-1:0] idx;
    logic            last;
    logic            store;  // 0: dropped key that only closes the run
    logic            ovf;
    logic            flip;   // sign bit was inverted
  } swi_entry_t;

endpackage

### design/swi_front.sv
// ----------------------------------------------------------------------------
// swi_front
// Accepts keys, numbers them, remaps them for compare and drops extras.
// ----------------------------------------------------------------------------
module swi_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [31:0]         key_i,
  input  logic                last_key_i,
  input  logic                signed_keys_i,
  output logic                push_valid_o,
  output swi_pkg::swi_entry_t push_data_o,
  input  logic                push_ready_i
);
  import swi_pkg::*;

  logic [CountW-1:0] count_q, count_d;
  logic              ovf_q, ovf_d;
  logic              has_room;
  logic              accept;

  assign has_room   = count_q < CountW'(MaxLen);
  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i & push_ready_i;

  assign push_valid_o      = in_valid_i & (has_room | last_key_i);
  assign push_data_o.ord   = key_i[KeyW-1:0] ^ {signed_keys_i, {(KeyW-1){1'b0}}};
  assign push_data_o.idx   = IdxW'(count_q);
  assign push_data_o.last  = last_key_i;
  assign push_data_o.store = has_room;
  assign push_data_o.ovf   = ovf_q | ~has_room;
  assign push_data_o.flip  = signed_keys_i;

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (accept) begin
      if (last_key_i) begin
        count_d = '0;
        ovf_d   = 1'b0;
      end else if (has_room) begin
        count_d = count_q + CountW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

### design/swi_fifo.sv
// ----------------------------------------------------------------------------
// swi_fifo
// Short queue of classified keys between front and back.
// ----------------------------------------------------------------------------
module swi_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  swi_pkg::swi_entry_t push_data_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output swi_pkg::swi_entry_t pop_data_o
);
  import swi_pkg::*;

  swi_entry_t          mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoPtrW:0]   cnt_q;
  logic                push, pop;

  assign push_ready_o = cnt_q != (FifoPtrW+1)'(FifoDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + FifoPtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + FifoPtrW'(1);
      end
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + (FifoPtrW+1)'(1);
        2'b01:   cnt_q <= cnt_q - (FifoPtrW+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### design/swi_back.sv
// ----------------------------------------------------------------------------
// swi_back
// Insertion cell array: keeps the run sorted as keys arrive, then drains it
// one result per cycle through the output register while not stalled.
// ----------------------------------------------------------------------------
module swi_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  swi_pkg::swi_entry_t pop_data_i,
  input  logic                descending_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         sorted_key_o,
  output logic [5:0]          source_index_o,
  output logic                last_result_o,
  output logic                overflow_o
);
  import swi_pkg::*;

  localparam logic StLoad  = 1'b0;
  localparam logic StDrain = 1'b1;

  logic              state_q;
  logic              ovf_q, flip_q;
  logic [KeyW-1:0]   ord_q [MaxLen];
  logic [IdxW-1:0]   idx_q [MaxLen];
  logic [MaxLen-1:0] vld_q;

  logic [KeyW-1:0]   ord_up [MaxLen];
  logic [IdxW-1:0]   idx_up [MaxLen];
  logic [KeyW-1:0]   ord_dn [MaxLen];
  logic [IdxW-1:0]   idx_dn [MaxLen];
  logic [MaxLen-1:0] after, after_prev, vld_prev;

  logic            insert, take, drain_step;
  logic            out_valid_q, out_last_q, out_ovf_q;
  logic [31:0]     out_key_q;
  logic [IdxW-1:0] out_idx_q;

  assign pop_ready_o = state_q == StLoad;
  assign take        = pop_valid_i & pop_ready_o;
  assign insert      = take & pop_data_i.store;
  assign drain_step  = (state_q == StDrain) & (~out_valid_q | out_ready_i);

  always_comb begin
    for (int i = 0; i < MaxLen; i++) begin
      after[i] = vld_q[i] & (descending_i ? (ord_q[i] < pop_data_i.ord)
                                          : (ord_q[i] > pop_data_i.ord));
    end
    after_prev = {after[MaxLen-2:0], 1'b0};
    vld_prev   = {vld_q[MaxLen-2:0], 1'b1};
    ord_dn[0]  = pop_data_i.ord;
    idx_dn[0]  = pop_data_i.idx;
    for (int i = 1; i < MaxLen; i++) begin
      ord_dn[i] = ord_q[i-1];
      idx_dn[i] = idx_q[i-1];
    end
    for (int i = 0; i < MaxLen - 1; i++) begin
      ord_up[i] = ord_q[i+1];
      idx_up[i] = idx_q[i+1];
    end
    ord_up[MaxLen-1] = ord_q[MaxLen-1];
    idx_up[MaxLen-1] = idx_q[MaxLen-1];
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxLen; i++) begin
      if (insert) begin
        if (after_prev[i]) begin
          ord_q[i] <= ord_dn[i];
          idx_q[i] <= idx_dn[i];
        end else if (vld_prev[i] && (after[i] || !vld_q[i])) begin
          ord_q[i] <= pop_data_i.ord;
          idx_q[i] <= pop_data_i.idx;
        end
      end else if (drain_step) begin
        ord_q[i] <= ord_up[i];
        idx_q[i] <= idx_up[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      flip_q <= pop_data_i.flip;
      if (pop_data_i.last) begin
        ovf_q <= pop_data_i.ovf;
      end
    end
    if (drain_step) begin
      out_key_q  <= 32'(ord_q[0] ^ {flip_q, {(KeyW-1){1'b0}}});
      out_idx_q  <= idx_q[0];
      out_last_q <= ~vld_q[1];
      out_ovf_q  <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (insert) begin
        vld_q <= vld_q | vld_prev;
      end else if (drain_step) begin
        vld_q <= vld_q >> 1;
      end
      if (drain_step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StLoad: begin
          if (take && pop_data_i.last) begin
            state_q <= StDrain;
          end
        end
        StDrain: begin
          if (drain_step && !vld_q[1]) begin
            state_q <= StLoad;
          end
        end
        default: state_q <= StLoad;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sorted_key_o   = out_key_q;
  assign source_index_o = out_idx_q;
  assign last_result_o  = out_last_q;
  assign overflow_o     = out_ovf_q;

endmodule

### design/sort_with_index.sv
// ----------------------------------------------------------------------------
// sort_with_index
// Stable argsort of one vector of up to 64 keys, ascending or descending.
// ----------------------------------------------------------------------------
// Keys stream in at one per cycle while the array loads; each is placed at its
// sorted position in a 64-cell insertion array as it arrives, one compare per
// cell. After the key flagged last, the run drains at one result per cycle
// unless the output stalls. While a run drains, the two-entry queue in front
// of the array takes the first keys of the next run, then input stalls until
// the drain is done. Equal keys leave in input order in both directions. Keys
// past the 64th are dropped and every result of that run carries overflow.
// Registers: 0x0 descending (reset 0), 0x4 signed_keys (reset 1); write only
// while the block is idle.
module sort_with_index (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [swi_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [31:0]               key_i,
  input  logic                      last_key_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [31:0]               sorted_key_o,
  output logic [5:0]                source_index_o,
  output logic                      last_result_o,
  output logic                      overflow_o
);
  import swi_pkg::*;

  logic       descending_q, signed_keys_q;
  logic       cfg_write;
  logic       push_valid, push_ready, pop_valid, pop_ready;
  swi_entry_t push_data, pop_data;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      descending_q  <= 1'b0;
      signed_keys_q <= 1'b1;
    end else if (cfg_write) begin
      unique case (paddr[2])
        RegDescending: descending_q  <= pwdata[0];
        RegSignedKeys: signed_keys_q <= pwdata[0];
        default:       descending_q  <= descending_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegDescending: prdata = {31'b0, descending_q};
      RegSignedKeys: prdata = {31'b0, signed_keys_q};
      default:       prdata = '0;
    endcase
  end

  swi_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .key_i         (key_i),
    .last_key_i    (last_key_i),
    .signed_keys_i (signed_keys_q),
    .push_valid_o  (push_valid),
    .push_data_o   (push_data),
    .push_ready_i  (push_ready)
  );

  swi_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  swi_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_data_i     (pop_data),
    .descending_i   (descending_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sorted_key_o   (sorted_key_o),
    .source_index_o (source_index_o),
    .last_result_o  (last_result_o),
    .overflow_o     (overflow_o)
  );

endmodule

### design/swi_checker.sv
// ----------------------------------------------------------------------------
// swi_checker
// Port-level checks for sort_with_index, bound to the top level.
// ----------------------------------------------------------------------------
module swi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        psel,
  input logic        pready,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] sorted_key_o,
  input logic [5:0]  source_index_o,
  input logic        last_result_o,
  input logic        overflow_o
);
  import swi_pkg::*;

  logic            out_xfer;
  logic            in_run_q;
  logic            run_ovf_q;
  logic [IdxW-1:0] run_cnt_q;

  assign out_xfer = out_valid_o & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_run_q  <= 1'b0;
      run_ovf_q <= 1'b0;
      run_cnt_q <= '0;
    end else if (out_xfer) begin
      in_run_q  <= ~last_result_o;
      run_ovf_q <= overflow_o;
      run_cnt_q <= last_result_o ? '0 : run_cnt_q + IdxW'(1);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sorted_key_o)
      && $stable(source_index_o) && $stable(last_result_o) && $stable(overflow_o))
    else $error("result changed while stalled");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel |-> pready)
    else $error("configuration port not ready");

  a_ovf_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && in_run_q |-> overflow_o == run_ovf_q)
    else $error("overflow changed within a run");

  a_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && run_cnt_q == IdxW'(MaxLen - 1) |-> last_result_o)
    else $error("run longer than the cell array");

endmodule

bind sort_with_index swi_checker u_swi_checker (.*);
